[hw/rtl/tcfv_pkg.sv]
// ----------------------------------------------------------------------------
// tcfv_pkg: shared types and constants of the control frame validator
// Frame layout constants, status codes, register indexes and the
// per-frame capture record used by the capture and judge stages.
// ----------------------------------------------------------------------------
package tcfv_pkg;

  localparam int unsigned COUNT_W = 33;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_W-1:0] HDR_BYTES     = 33'd16;
  localparam logic [COUNT_W-1:0] POS_VERSION   = 33'd8;
  localparam logic [COUNT_W-1:0] POS_OPCODE    = 33'd9;
  localparam logic [COUNT_W-1:0] POS_LENGTH    = 33'd12;
  localparam logic [COUNT_W-1:0] PAYLOAD_END   = 33'd28;
  localparam logic [31:0]        START_PAYLOAD = 32'd12;

  localparam logic [7:0]  START_OPCODE = 8'd1;
  localparam logic [7:0]  STOP_OPCODE  = 8'd2;
  localparam logic [15:0] MTU_LOW      = 16'd1280;
  localparam logic [15:0] MTU_HIGH     = 16'd9000;

  // header magic, first byte on the left
  localparam logic [0:7][7:0] HDR_SIGNATURE = {
    8'h42, 8'h59, 8'h53, 8'h50, 8'h54, 8'h55, 8'h4E, 8'h31
  };

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_RESERVED   = 4'd4,
    ST_TOO_LARGE  = 4'd5,
    ST_LENGTH     = 4'd6,
    ST_STOP_LEN   = 4'd7,
    ST_OPCODE     = 4'd8,
    ST_START_LEN  = 4'd9,
    ST_LOCAL      = 4'd10,
    ST_PEER       = 4'd11,
    ST_PORT       = 4'd12,
    ST_MTU        = 4'd13
  } status_t;

  typedef enum logic [2:0] {
    CFG_VERSION     = 3'd0,
    CFG_MAX_PAYLOAD = 3'd1,
    CFG_LOCAL_ADDR  = 3'd2,
    CFG_MASK        = 3'd3,
    CFG_PREFIX      = 3'd4,
    CFG_FIRST_PEER  = 3'd5,
    CFG_LAST_PEER   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [31:0] max_payload;
    logic [31:0] local_address;
    logic [31:0] overlay_mask;
    logic [31:0] overlay_prefix;
    logic [31:0] first_peer;
    logic [31:0] last_peer;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    expected_version: 8'd1,
    max_payload:      32'd65536,
    local_address:    32'h0A00_0001,
    overlay_mask:     32'hFFFF_FF00,
    overlay_prefix:   32'h0A00_0000,
    first_peer:       32'h0A00_0002,
    last_peer:        32'h0A00_00FE
  };

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               magic_good;
    logic [7:0]         version;
    logic [7:0]         opcode;
    logic               reserved_nz;
    logic [31:0]        length;
    logic [2:0][31:0]   payload;
  } frame_t;

  localparam frame_t FRAME_CLEAR = '{
    count:       '0,
    magic_good:  1'b1,
    version:     8'd0,
    opcode:      8'd0,
    reserved_nz: 1'b0,
    length:      32'd0,
    payload:     '0
  };

endpackage

[hw/rtl/tcfv_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tcfv_cfg_regs: configuration register file
// Seven registers written by index over the cfg channel; always ready.
// ----------------------------------------------------------------------------
module tcfv_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output tcfv_pkg::cfg_t cfg
);
  import tcfv_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_VERSION:     cfg_nxt.expected_version = cfg_data[7:0];
        CFG_MAX_PAYLOAD: cfg_nxt.max_payload      = cfg_data;
        CFG_LOCAL_ADDR:  cfg_nxt.local_address    = cfg_data;
        CFG_MASK:        cfg_nxt.overlay_mask     = cfg_data;
        CFG_PREFIX:      cfg_nxt.overlay_prefix   = cfg_data;
        CFG_FIRST_PEER:  cfg_nxt.first_peer       = cfg_data;
        CFG_LAST_PEER:   cfg_nxt.last_peer        = cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/tcfv_capture.sv]
// ----------------------------------------------------------------------------
// tcfv_capture: per-byte frame tracking
// Updates the byte counter, header flags and captured fields on every
// accepted beat; on the last beat hands the frame record to the judge.
// ----------------------------------------------------------------------------
module tcfv_capture (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_frame_end,
  input  logic             snap_take,
  output logic             snap_valid,
  output tcfv_pkg::frame_t snap
);
  import tcfv_pkg::*;

  frame_t     frame_r;
  frame_t     frame_nxt;
  frame_t     snap_r;
  logic       snap_valid_r;
  logic       snap_valid_nxt;
  logic       accept;
  logic [4:0] off;

  assign in_stall   = snap_valid_r && !snap_take;
  assign accept     = in_valid && !in_stall;
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    frame_nxt = frame_r;
    off       = frame_r.count[4:0] - HDR_BYTES[4:0];
    if (frame_r.count < POS_VERSION) begin
      if (in_data_byte != HDR_SIGNATURE[frame_r.count[2:0]]) begin
        frame_nxt.magic_good = 1'b0;
      end
    end else if (frame_r.count == POS_VERSION) begin
      frame_nxt.version = in_data_byte;
    end else if (frame_r.count == POS_OPCODE) begin
      frame_nxt.opcode = in_data_byte;
    end else if (frame_r.count < POS_LENGTH) begin
      if (in_data_byte != 8'd0) begin
        frame_nxt.reserved_nz = 1'b1;
      end
    end else if (frame_r.count < HDR_BYTES) begin
      frame_nxt.length = {frame_r.length[23:0], in_data_byte};
    end else if (frame_r.count < PAYLOAD_END) begin
      // payload bytes 0..11 fill three big-endian words
      if (off[3:2] != 2'd3) begin
        frame_nxt.payload[off[3:2]] = {frame_r.payload[off[3:2]][23:0], in_data_byte};
      end
    end
    if (frame_r.count != COUNT_MAX) begin
      frame_nxt.count = frame_r.count + 33'd1;
    end

    snap_valid_nxt = snap_valid_r;
    if (accept && in_frame_end) begin
      snap_valid_nxt = 1'b1;
    end else if (snap_take) begin
      snap_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r      <= FRAME_CLEAR;
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      if (accept) begin
        frame_r <= in_frame_end ? FRAME_CLEAR : frame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame_end) begin
      snap_r <= frame_nxt;
    end
  end

endmodule

[hw/rtl/tcfv_judge.sv]
// ----------------------------------------------------------------------------
// tcfv_judge: end-of-frame checks and result register
// Picks the first failing check of a finished frame and holds the result
// beat until the receiver takes it.
// ----------------------------------------------------------------------------
module tcfv_judge (
  input  logic             clk,
  input  logic             rst_n,
  input  tcfv_pkg::cfg_t   cfg,
  input  logic             snap_valid,
  input  tcfv_pkg::frame_t snap,
  output logic             snap_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_status,
  output logic [7:0]       out_request_code,
  output logic [31:0]      out_local_addr_out,
  output logic [31:0]      out_peer_addr_out,
  output logic [15:0]      out_proxy_port,
  output logic [15:0]      out_link_mtu
);
  import tcfv_pkg::*;

  logic               out_valid_r;
  status_t            status_r;
  logic [7:0]         req_r;
  logic [31:0]        loc_r;
  logic [31:0]        peer_r;
  logic [15:0]        port_r;
  logic [15:0]        mtu_r;

  status_t            status_nxt;
  logic [7:0]         req_nxt;
  logic [31:0]        loc_nxt;
  logic [31:0]        peer_nxt;
  logic [15:0]        port_nxt;
  logic [15:0]        mtu_nxt;
  logic [COUNT_W-1:0] expect_count;
  logic [31:0]        loc;
  logic [31:0]        peer;
  logic [15:0]        port;
  logic [15:0]        mtu;
  logic               peer_bad;

  // result register is free when empty or being drained this cycle
  assign snap_take = !out_valid_r || !out_stall;

  assign loc  = snap.payload[0];
  assign peer = snap.payload[1];
  assign port = snap.payload[2][31:16];
  assign mtu  = snap.payload[2][15:0];

  always_comb begin
    expect_count = {1'b0, snap.length} + HDR_BYTES;
    peer_bad = ((peer & cfg.overlay_mask) != cfg.overlay_prefix) ||
               (peer < cfg.first_peer) || (peer > cfg.last_peer);
    req_nxt  = 8'd0;
    loc_nxt  = 32'd0;
    peer_nxt = 32'd0;
    port_nxt = 16'd0;
    mtu_nxt  = 16'd0;
    priority if (snap.count < HDR_BYTES) begin
      status_nxt = ST_SHORT;
    end else if (!snap.magic_good) begin
      status_nxt = ST_MAGIC;
    end else if (snap.version != cfg.expected_version) begin
      status_nxt = ST_VERSION;
    end else if (snap.reserved_nz) begin
      status_nxt = ST_RESERVED;
    end else if (snap.length > cfg.max_payload) begin
      status_nxt = ST_TOO_LARGE;
    end else if (snap.count != expect_count) begin
      status_nxt = ST_LENGTH;
    end else if (snap.opcode == STOP_OPCODE) begin
      if (snap.length != 32'd0) begin
        status_nxt = ST_STOP_LEN;
      end else begin
        status_nxt = ST_OK;
        req_nxt    = snap.opcode;
      end
    end else if (snap.opcode != START_OPCODE) begin
      status_nxt = ST_OPCODE;
    end else if (snap.length != START_PAYLOAD) begin
      status_nxt = ST_START_LEN;
    end else if (loc != cfg.local_address) begin
      status_nxt = ST_LOCAL;
    end else if (peer_bad) begin
      status_nxt = ST_PEER;
    end else if (port == 16'd0) begin
      status_nxt = ST_PORT;
    end else if ((mtu < MTU_LOW) || (mtu > MTU_HIGH)) begin
      status_nxt = ST_MTU;
    end else begin
      status_nxt = ST_OK;
      req_nxt    = snap.opcode;
      loc_nxt    = loc;
      peer_nxt   = peer;
      port_nxt   = port;
      mtu_nxt    = mtu;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_take) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_valid) begin
      status_r <= status_nxt;
      req_r    <= req_nxt;
      loc_r    <= loc_nxt;
      peer_r   <= peer_nxt;
      port_r   <= port_nxt;
      mtu_r    <= mtu_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_request_code   = req_r;
  assign out_local_addr_out = loc_r;
  assign out_peer_addr_out  = peer_r;
  assign out_proxy_port     = port_r;
  assign out_link_mtu       = mtu_r;

endmodule

[hw/rtl/tunnel_control_frame_validator_unit.sv]
// ----------------------------------------------------------------------------
// tunnel_control_frame_validator_unit: tunnel control frame validator
// One byte beat per cycle while not stalled; the byte capture register sets
// the rate. Results pass the capture snapshot and judge result registers.
// Sync reset clears frame state, output valid and loads register defaults.
// ----------------------------------------------------------------------------
module tunnel_control_frame_validator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [7:0]  out_request_code,
  output logic [31:0] out_local_addr_out,
  output logic [31:0] out_peer_addr_out,
  output logic [15:0] out_proxy_port,
  output logic [15:0] out_link_mtu,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tcfv_pkg::*;

  cfg_t   cfg;
  frame_t snap;
  logic   snap_valid;
  logic   snap_take;

  tcfv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcfv_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .snap_take    (snap_take),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  tcfv_judge u_judge (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .snap_valid         (snap_valid),
    .snap               (snap),
    .snap_take          (snap_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_request_code   (out_request_code),
    .out_local_addr_out (out_local_addr_out),
    .out_peer_addr_out  (out_peer_addr_out),
    .out_proxy_port     (out_proxy_port),
    .out_link_mtu       (out_link_mtu)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: tunnel control frame validator regression
// Feeds control frames byte by byte (directed table, then random frames
// under several register settings), predicts each frame verdict from the
// directed table or an independent model and checks every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import tcfv_pkg::*;

  localparam int          SETTLE      = 8;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 400000;
  localparam int          MAX_REPORTS = 10;

  localparam logic [15:0] MTU_MIN   = 16'd1280;
  localparam logic [15:0] MTU_MAX   = 16'd9000;
  localparam logic [7:0]  FRAME_SIG [8] = '{
    8'h42, 8'h59, 8'h53, 8'h50, 8'h54, 8'h55, 8'h4E, 8'h31
  };

  localparam cfg_t DEFAULT_CFG = '{
    expected_version: 8'd1,
    max_payload:      32'd65536,
    local_address:    32'h0A00_0001,
    overlay_mask:     32'hFFFF_FF00,
    overlay_prefix:   32'h0A00_0000,
    first_peer:       32'h0A00_0002,
    last_peer:        32'h0A00_00FE
  };

  typedef enum int {
    FK_START_OK, FK_STOP_OK, FK_SHORT, FK_MAGIC, FK_VERSION, FK_RESERVED,
    FK_TOO_LARGE, FK_LENGTH, FK_STOP_LEN, FK_OPCODE, FK_START_LEN, FK_LOCAL,
    FK_PEER, FK_PORT, FK_MTU, FK_NOISE
  } frame_kind_e;

  typedef struct packed {
    status_t     st;
    logic [7:0]  code;
    logic [31:0] loc;
    logic [31:0] peer;
    logic [15:0] port;
    logic [15:0] mtu;
  } verdict_t;

  typedef struct packed {
    logic [32:0]      count;
    logic             magic_ok;
    logic [7:0]       ver;
    logic [7:0]       opc;
    logic             rsv_bad;
    logic [31:0]      len;
    logic [2:0][31:0] pl;
  } frame_acc_t;

  localparam frame_acc_t ACC_IDLE = {33'd0, 1'b1, 8'd0, 8'd0, 1'b0, 32'd0, 96'd0};

  typedef struct packed {
    frame_kind_e kind;
    logic        fixed;
    status_t     st;
  } plan_row_t;

  // directed frames, run under reset register values
  localparam int PLAN_ROWS = 18;
  plan_row_t plan [PLAN_ROWS] = '{
    '{FK_STOP_OK,   1'b1, ST_OK},
    '{FK_START_OK,  1'b0, ST_OK},
    '{FK_SHORT,     1'b1, ST_SHORT},
    '{FK_MAGIC,     1'b1, ST_MAGIC},
    '{FK_VERSION,   1'b1, ST_VERSION},
    '{FK_RESERVED,  1'b1, ST_RESERVED},
    '{FK_TOO_LARGE, 1'b1, ST_TOO_LARGE},
    '{FK_LENGTH,    1'b1, ST_LENGTH},
    '{FK_STOP_LEN,  1'b1, ST_STOP_LEN},
    '{FK_OPCODE,    1'b1, ST_OPCODE},
    '{FK_START_LEN, 1'b1, ST_START_LEN},
    '{FK_LOCAL,     1'b1, ST_LOCAL},
    '{FK_PEER,      1'b1, ST_PEER},
    '{FK_PORT,      1'b1, ST_PORT},
    '{FK_MTU,       1'b1, ST_MTU},
    '{FK_NOISE,     1'b0, ST_OK},
    '{FK_START_OK,  1'b0, ST_OK},
    '{FK_SHORT,     1'b1, ST_SHORT}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [7:0]  out_request_code;
  logic [31:0] out_local_addr_out;
  logic [31:0] out_peer_addr_out;
  logic [15:0] out_proxy_port;
  logic [15:0] out_link_mtu;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [31:0] cfg_data;

  cfg_t        cfg = DEFAULT_CFG;
  frame_acc_t  acc = ACC_IDLE;
  verdict_t    pending_verdicts[$];
  logic [7:0]  fbuf[$];

  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  logic        long_hold = 1'b0;
  int          hold_count = 0;
  int unsigned cycles = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          ok_frames = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          settings = 1;

  tunnel_control_frame_validator_unit DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_verdicts.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---- frame predictor ----
  function automatic void absorb_byte(logic [7:0] b);
    int w;
    if (acc.count < 33'd8) begin
      if (b != FRAME_SIG[acc.count[2:0]]) acc.magic_ok = 1'b0;
    end else if (acc.count == 33'd8) begin
      acc.ver = b;
    end else if (acc.count == 33'd9) begin
      acc.opc = b;
    end else if (acc.count < 33'd12) begin
      if (b != 8'd0) acc.rsv_bad = 1'b1;
    end else if (acc.count < 33'd16) begin
      acc.len = {acc.len[23:0], b};
    end else if (acc.count < 33'd28) begin
      w = int'((acc.count - 33'd16) >> 2);
      acc.pl[w] = {acc.pl[w][23:0], b};
    end
    if (acc.count != '1) acc.count = acc.count + 33'd1;
  endfunction

  function automatic verdict_t judge_frame();
    verdict_t    v;
    logic [31:0] loc, peer;
    logic [15:0] port, mtu;
    v = '0;
    loc = acc.pl[0];
    peer = acc.pl[1];
    port = acc.pl[2][31:16];
    mtu = acc.pl[2][15:0];
    if (acc.count < 33'd16) v.st = ST_SHORT;
    else if (!acc.magic_ok) v.st = ST_MAGIC;
    else if (acc.ver != cfg.expected_version) v.st = ST_VERSION;
    else if (acc.rsv_bad) v.st = ST_RESERVED;
    else if (acc.len > cfg.max_payload) v.st = ST_TOO_LARGE;
    else if (acc.count != 33'd16 + {1'b0, acc.len}) v.st = ST_LENGTH;
    else if (acc.opc == STOP_OPCODE) begin
      if (acc.len != 32'd0) v.st = ST_STOP_LEN;
      else v.code = acc.opc;
    end else if (acc.opc != START_OPCODE) v.st = ST_OPCODE;
    else if (acc.len != 32'd12) v.st = ST_START_LEN;
    else if (loc != cfg.local_address) v.st = ST_LOCAL;
    else if ((peer & cfg.overlay_mask) != cfg.overlay_prefix ||
             peer < cfg.first_peer || peer > cfg.last_peer) v.st = ST_PEER;
    else if (port == 16'd0) v.st = ST_PORT;
    else if (mtu < MTU_MIN || mtu > MTU_MAX) v.st = ST_MTU;
    else begin
      v.code = acc.opc;
      v.loc = loc;
      v.peer = peer;
      v.port = port;
      v.mtu = mtu;
    end
    return v;
  endfunction

  // ---- frame generation ----
  function automatic logic [31:0] pick_peer();
    logic [31:0] p;
    for (int i = 0; i < 8; i++) begin
      p = ($urandom & ~cfg.overlay_mask) | (cfg.overlay_prefix & cfg.overlay_mask);
      if (p >= cfg.first_peer && p <= cfg.last_peer) return p;
    end
    return cfg.first_peer;
  endfunction

  function automatic void put_word(logic [31:0] v);
    for (int i = 3; i >= 0; i--) fbuf.push_back(v[8*i +: 8]);
  endfunction

  function automatic void build_frame(frame_kind_e k);
    logic [31:0] loc, peer, len;
    logic [15:0] port, mtu, rsv;
    logic [7:0]  ver, opc;
    logic [95:0] body;
    int          n, pick;
    fbuf.delete();
    if (k == FK_NOISE) begin
      n = $urandom_range(40, 1);
      repeat (n) fbuf.push_back(8'($urandom));
      return;
    end
    ver = cfg.expected_version;
    opc = START_OPCODE;
    rsv = 16'd0;
    len = 32'd12;
    n = 12;
    loc = cfg.local_address;
    peer = pick_peer();
    pick = $urandom_range(2);
    port = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(65535, 1));
    pick = $urandom_range(2);
    mtu = (pick == 0) ? MTU_MIN : (pick == 1) ? MTU_MAX : 16'($urandom_range(9000, 1280));
    case (k)
      FK_STOP_OK: begin
        opc = STOP_OPCODE;
        len = 32'd0;
        n = 0;
      end
      FK_VERSION:  ver = ver ^ 8'($urandom_range(255, 1));
      FK_RESERVED: rsv = 16'($urandom_range(65535, 1));
      FK_TOO_LARGE: begin
        len = $urandom;
        if (len <= cfg.max_payload) len = cfg.max_payload + 32'd1;
        n = $urandom_range(4);
      end
      FK_STOP_LEN: begin
        opc = STOP_OPCODE;
        n = $urandom_range(20, 1);
        len = n;
      end
      FK_OPCODE: begin
        opc = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255, 3));
        n = $urandom_range(20);
        len = n;
      end
      FK_START_LEN: begin
        n = $urandom_range(19);
        if (n >= 12) n++;
        len = n;
      end
      FK_LOCAL: loc = loc ^ $urandom_range(32'hFFFF_FFFF, 1);
      FK_PEER: begin
        case ($urandom_range(3))
          0:       peer = cfg.first_peer - 32'd1;
          1:       peer = cfg.last_peer + 32'd1;
          2:       peer = peer ^ 32'h8000_0000;
          default: peer = cfg.overlay_prefix;
        endcase
      end
      FK_PORT: port = 16'd0;
      FK_MTU: begin
        case ($urandom_range(4))
          0:       mtu = MTU_MIN - 16'd1;
          1:       mtu = MTU_MAX + 16'd1;
          2:       mtu = 16'd0;
          3:       mtu = 16'($urandom_range(65535, 9001));
          default: mtu = 16'($urandom_range(1279, 1));
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) fbuf.push_back(FRAME_SIG[i]);
    fbuf.push_back(ver);
    fbuf.push_back(opc);
    fbuf.push_back(rsv[15:8]);
    fbuf.push_back(rsv[7:0]);
    put_word(len);
    body = {loc, peer, port, mtu};
    for (int i = 0; i < n; i++)
      fbuf.push_back((i < 12) ? body[95 - 8*i -: 8] : 8'($urandom));
    case (k)
      FK_MAGIC: begin
        pick = $urandom_range(7);
        fbuf[pick] = fbuf[pick] ^ (8'd1 << $urandom_range(7));
      end
      FK_SHORT: begin
        n = $urandom_range(15, 1);
        while (fbuf.size() > n) void'(fbuf.pop_back());
      end
      FK_LENGTH: begin
        // either cut into the payload or run past its declared end
        if ($urandom_range(1) == 0) repeat ($urandom_range(12, 1)) void'(fbuf.pop_back());
        else repeat ($urandom_range(20, 1)) fbuf.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) return FK_START_OK;
    if (r < 60) return FK_STOP_OK;
    return frame_kind_e'($urandom_range(FK_NOISE, FK_SHORT));
  endfunction

  // ---- drivers ----
  task automatic send_byte(logic [7:0] b, logic last, logic fixed, verdict_t pinned);
    verdict_t v;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
    if (last) begin
      v = judge_frame();
      acc = ACC_IDLE;
      pending_verdicts.push_back(fixed ? pinned : v);
      frames_sent++;
      if (v.st == ST_OK) ok_frames++;
    end
  endtask

  task automatic send_frame(frame_kind_e k, logic fixed, status_t st);
    verdict_t   pinned;
    logic [7:0] bytes[$];
    build_frame(k);
    bytes = fbuf;
    pinned = '0;
    pinned.st = st;
    if (st == ST_OK) pinned.code = STOP_OPCODE;
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, fixed, pinned);
  endtask

  task automatic wait_idle();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(int byte_goal, int frame_goal);
    int b0, f0;
    b0 = bytes_sent;
    f0 = frames_sent;
    while (bytes_sent - b0 < byte_goal || frames_sent - f0 < frame_goal)
      send_frame(pick_kind(), 1'b0, ST_OK);
    in_valid <= 1'b0;
    wait_idle();
  endtask

  task automatic load_config(cfg_t c);
    logic [31:0] d;
    cfg_valid <= 1'b1;
    for (int i = CFG_VERSION; i <= CFG_LAST_PEER; i++) begin
      case (cfg_index_t'(i))
        CFG_VERSION: begin
          d = $urandom;  // upper bits are don't-care
          d[7:0] = c.expected_version;
        end
        CFG_MAX_PAYLOAD: d = c.max_payload;
        CFG_LOCAL_ADDR:  d = c.local_address;
        CFG_MASK:        d = c.overlay_mask;
        CFG_PREFIX:      d = c.overlay_prefix;
        CFG_FIRST_PEER:  d = c.first_peer;
        default:         d = c.last_peer;
      endcase
      cfg_index <= cfg_index_t'(i);
      cfg_data <= d;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cfg = c;
    settings++;
  endtask

  // ---- result side ----
  always @(posedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  task automatic report_bad(string what, verdict_t want, verdict_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  want st=%0d code=%h loc=%h peer=%h port=%0d mtu=%0d",
               want.st, want.code, want.loc, want.peer, want.port, want.mtu);
      $display("  got  st=%0d code=%h loc=%h peer=%h port=%0d mtu=%0d",
               seen.st, seen.code, seen.loc, seen.peer, seen.port, seen.mtu);
    end
  endtask

  always @(posedge clk) begin
    verdict_t seen, want;
    if (rst_n && out_valid && !out_stall) begin
      seen.st = status_t'(out_status);
      seen.code = out_request_code;
      seen.loc = out_local_addr_out;
      seen.peer = out_peer_addr_out;
      seen.port = out_proxy_port;
      seen.mtu = out_link_mtu;
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_bad("Result beat with nothing expected", '0, seen);
      end else begin
        want = pending_verdicts.pop_front();
        if (seen.st !== want.st || seen.code !== want.code || seen.loc !== want.loc ||
            seen.peer !== want.peer || seen.port !== want.port || seen.mtu !== want.mtu)
          report_bad("Result mismatch", want, seen);
      end
    end
  end

  // ---- sequence ----
  initial begin
    cfg_t        c;
    int          k;
    logic [31:0] a, b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'd0;
    in_frame_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_VERSION;
    cfg_data = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender light, receiver heavy
    snd_idle_pct = 14;
    rcv_idle_pct = 62;
    for (int i = 0; i < PLAN_ROWS; i++) send_frame(plan[i].kind, plan[i].fixed, plan[i].st);
    in_valid <= 1'b0;
    wait_idle();
    run_random(150, 6);

    c = '1;
    load_config(c);
    run_random(150, 6);

    // sender heavy, receiver light
    snd_idle_pct = 62;
    rcv_idle_pct = 14;
    c = '0;
    load_config(c);
    run_random(150, 6);

    c.expected_version = 8'($urandom);
    c.max_payload = $urandom_range(40, 12);
    c.local_address = $urandom;
    k = $urandom_range(16);
    c.overlay_mask = 32'hFFFF_FFFF << k;
    c.overlay_prefix = $urandom & c.overlay_mask;
    a = c.overlay_prefix | ($urandom & ~c.overlay_mask);
    b = c.overlay_prefix | ($urandom & ~c.overlay_mask);
    c.first_peer = (a < b) ? a : b;
    c.last_peer = (a < b) ? b : a;
    load_config(c);
    run_random(150, 6);

    // no idling; a long output stall backs the block up into its input
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    c = DEFAULT_CFG;
    c.max_payload = 32'd12;
    load_config(c);
    long_hold <= 1'b1;
    run_random(150, 6);

    $display("Checked %0d result beats from %0d frames (%0d bytes, %0d valid frames)",
             results_seen, frames_sent, bytes_sent, ok_frames);
    $display("Covered every status code over %0d register settings, with idle gaps,"
             , settings);
    $display("  a long output hold-off and drained pauses between settings");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d bad result beats", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
